FILE: design/rsl_pkg.sv
// ----------------------------------------------------------------------------
// rsl_pkg: shared types and constants of the per-source rate limiter
// beat payloads, table entry layout, result codes and sequencer states
// ----------------------------------------------------------------------------
package rsl_pkg;

  localparam int SLOTS_DEF = 16;

  localparam logic [63:0] WINDOW_MS = 64'd1000;

  localparam logic [2:0] EV_OFF     = 3'd0;
  localparam logic [2:0] EV_COUNTED = 3'd1;
  localparam logic [2:0] EV_REFUSED = 3'd2;
  localparam logic [2:0] EV_NEW     = 3'd3;
  localparam logic [2:0] EV_EVICTED = 3'd4;

  typedef struct packed {
    logic [31:0] source_address;
    logic [63:0] now_ms;
  } in_t;

  typedef struct packed {
    logic       limited;
    logic [2:0] event_res;
  } out_t;

  typedef struct packed {
    logic [31:0] source;
    logic [63:0] window_start;
    logic [15:0] hits;
  } entry_t;

  typedef struct packed {
    logic   en;
    entry_t data;
  } tbl_wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_RESP
  } state_t;

endpackage

FILE: design/rsl_table.sv
// ----------------------------------------------------------------------------
// rsl_table: slot table of the rate limiter
// one write and one registered read per cycle; per-slot valid bits make
// unwritten slots read as all zero right after reset
// ----------------------------------------------------------------------------
module rsl_table #(
  parameter int SLOTS = rsl_pkg::SLOTS_DEF,
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  rsl_pkg::tbl_wr_t wr,
  input  logic [IW-1:0]    wr_addr,
  input  logic [IW-1:0]    rd_addr,
  output rsl_pkg::entry_t  rd_data
);

  rsl_pkg::entry_t mem [SLOTS];
  rsl_pkg::entry_t rd_raw;
  logic [SLOTS-1:0] vld;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
    rd_raw <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr_addr] <= 1'b1;
      end
      rd_vld <= vld[rd_addr];
    end
  end

  assign rd_data = rd_vld ? rd_raw : '0;

endmodule

FILE: design/rsl_ctrl.sv
// ----------------------------------------------------------------------------
// rsl_ctrl: request sequencer of the rate limiter
// scans the slot table one slot per cycle unless limiting is off, decides the
// outcome and writes the chosen slot back, then loads the output register
// ----------------------------------------------------------------------------
module rsl_ctrl #(
  parameter int SLOTS = rsl_pkg::SLOTS_DEF,
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wen,
  input  logic [15:0]      cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  rsl_pkg::in_t     in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rsl_pkg::out_t    out_data,
  output rsl_pkg::tbl_wr_t wr,
  output logic [IW-1:0]    wr_addr,
  output logic [IW-1:0]    rd_addr,
  input  rsl_pkg::entry_t  rd_data
);

  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  rsl_pkg::state_t state, state_next;
  rsl_pkg::in_t    item;
  rsl_pkg::entry_t m_entry;
  rsl_pkg::out_t   res, res_next;
  logic [15:0]     limit;
  logic [IW-1:0]   scan_idx;
  logic [IW-1:0]   old_idx;
  logic [63:0]     old_start;
  logic            res_load;
  logic            accept;
  logic            hit, empty, last, older;
  logic [IW-1:0]   evict_idx;
  logic [63:0]     age;
  logic            expired;
  logic [15:0]     hits_eff;
  logic            refuse;
  logic            out_free;

  assign accept    = in_valid && in_ready;
  assign hit       = rd_data.source == item.source_address;
  assign empty     = rd_data.source == 32'd0;
  assign last      = scan_idx == LAST;
  assign older     = (scan_idx == '0) || (rd_data.window_start < old_start);
  assign evict_idx = older ? scan_idx : old_idx;
  assign age       = item.now_ms - m_entry.window_start;
  assign expired   = age >= rsl_pkg::WINDOW_MS;
  assign hits_eff  = expired ? 16'd0 : m_entry.hits;
  assign refuse    = hits_eff >= limit;
  assign out_free  = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rsl_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (limit == 16'd0) ? rsl_pkg::ST_RESP : rsl_pkg::ST_SCAN;
        end
      end
      rsl_pkg::ST_SCAN: begin
        if (hit) begin
          state_next = rsl_pkg::ST_UPDATE;
        end else if (empty || last) begin
          state_next = rsl_pkg::ST_RESP;
        end
      end
      rsl_pkg::ST_UPDATE: begin
        state_next = rsl_pkg::ST_RESP;
      end
      rsl_pkg::ST_RESP: begin
        if (out_free) begin
          state_next = rsl_pkg::ST_IDLE;
        end
      end
      default: state_next = rsl_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    rd_addr  = '0;
    wr       = '0;
    wr_addr  = scan_idx;
    res_load = 1'b0;
    res_next = '0;
    unique case (state)
      rsl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        res_load = accept && (limit == 16'd0);
        res_next = '{limited: 1'b0, event_res: rsl_pkg::EV_OFF};
      end
      rsl_pkg::ST_SCAN: begin
        rd_addr = last ? '0 : scan_idx + IW'(1);
        if (!hit && (empty || last)) begin
          wr.en                = 1'b1;
          wr.data.source       = item.source_address;
          wr.data.window_start = item.now_ms;
          wr.data.hits         = 16'd1;
          wr_addr              = empty ? scan_idx : evict_idx;
          res_load             = 1'b1;
          res_next = '{limited: 1'b0,
                       event_res: empty ? rsl_pkg::EV_NEW : rsl_pkg::EV_EVICTED};
        end
      end
      rsl_pkg::ST_UPDATE: begin
        wr.en                = 1'b1;
        wr.data.source       = m_entry.source;
        wr.data.window_start = expired ? item.now_ms : m_entry.window_start;
        wr.data.hits         = refuse ? hits_eff : hits_eff + 16'd1;
        res_load             = 1'b1;
        res_next.limited     = refuse;
        res_next.event_res   = refuse ? rsl_pkg::EV_REFUSED : rsl_pkg::EV_COUNTED;
      end
      rsl_pkg::ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rsl_pkg::ST_IDLE;
      limit     <= 16'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        limit <= cfg_wdata;
      end
      if (state == rsl_pkg::ST_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item     <= in_data;
      scan_idx <= '0;
    end else if (state == rsl_pkg::ST_SCAN && !hit && !empty && !last) begin
      scan_idx <= scan_idx + IW'(1);
    end
    if (state == rsl_pkg::ST_SCAN) begin
      m_entry <= rd_data;
      if (older) begin
        old_idx   <= scan_idx;
        old_start <= rd_data.window_start;
      end
    end
    if (res_load) begin
      res <= res_next;
    end
    if (state == rsl_pkg::ST_RESP && out_free) begin
      out_data <= res;
    end
  end

endmodule

FILE: design/per_source_rate_limiter_top.sv
// ----------------------------------------------------------------------------
// per_source_rate_limiter_top: fixed-window rate limiter keyed by source
// address, with a table of SLOTS entries scanned one slot per cycle
// ----------------------------------------------------------------------------
// One request is handled at a time. With limiting off a request skips the
// table and goes straight to the response state. Otherwise the table is read
// one slot per cycle through its single registered read port until the scan
// ends at a matching or empty slot or at the last slot; a match adds an update
// step for the read-modify-write. The table is empty at once after reset;
// no clearing pass is needed. A new request is taken while the previous
// result beat still waits at the output.
module per_source_rate_limiter_top #(
  parameter int SLOTS = rsl_pkg::SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wen,
  input  logic [15:0]   cfg_wdata,
  input  logic          in_valid,
  output logic          in_ready,
  input  rsl_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rsl_pkg::out_t out_data
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  rsl_pkg::tbl_wr_t wr;
  logic [IW-1:0]    wr_addr;
  logic [IW-1:0]    rd_addr;
  rsl_pkg::entry_t  rd_data;

  rsl_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .wr        (wr),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  rsl_table #(
    .SLOTS(SLOTS)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule
